/* rtl/dopq_pkg.sv */
// Shared types and codes for the drop-oldest packet ring queue.
// No dependencies; used by the top level and its checker.
package dopq_pkg;

  localparam int LEN_W  = 12;
  localparam int PRIO_W = 16;
  localparam int CAP_W  = 13;
  localparam int CNT_W  = 5;

  typedef enum logic [2:0] {
    CMD_ENQ  = 3'd0,
    CMD_DATA = 3'd1,
    CMD_DEQ  = 3'd2,
    CMD_READ = 3'd3,
    CMD_DISC = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_SMALL    = 2'd3
  } status_e;

  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_BYTES = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RBYTE,
    ST_DEQ,
    ST_DISC,
    ST_ENQ_LAST,
    ST_EVICT,
    ST_ENQ_WR
  } state_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [7:0]        data_byte;
    logic [LEN_W-1:0]  pkt_length;
    logic [PRIO_W-1:0] pkt_priority;
    logic [CAP_W-1:0]  read_capacity;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LEN_W-1:0]  out_length;
    logic [PRIO_W-1:0] out_priority;
    logic [7:0]        out_byte;
    logic              last_byte;
    logic [CNT_W-1:0]  dropped;
    logic [CNT_W-1:0]  queued_packets;
  } rsp_t;

endpackage

/* rtl/drop_oldest_packet_ring_queue.sv */
// Drop-oldest packet queue: descriptor ring plus circular byte store.
// Depends on dopq_pkg.
//
// Usage:
//  - Request channel (in_valid/in_stall/in_req) carries one command per request:
//    enqueue begin, data byte, dequeue begin, read byte, discard head.
//  - Response channel (out_valid/out_stall/out_rsp) returns exactly one
//    response per request, in order. A response sits in an output register;
//    a new request is taken once that register is empty or in the cycle its
//    response is taken.
//  - Config port (cfg_we/cfg_index/cfg_data): index 0 sets descriptor slots,
//    index 1 sets byte capacity; values are clamped and the queue empties.
//    Write it only when no request is in flight.
//  - Sequencing of a request, set by the one-read-per-cycle descriptor memory and
//    the registered byte-store read:
//      data byte, rejects, empty cases: answered in the idle state
//      read byte, dequeue, discard: idle, then the RBYTE, DEQ or DISC state
//      enqueue: idle if empty; else ENQ_LAST, one EVICT per drop, ENQ_WR.
//    Eviction walks the head one descriptor per cycle through a shared
//    drop-head path.
//  - in_stall is high while a request is in progress and while a response
//    is held by out_stall.
//  - Reset (rst, synchronous) empties the queue and restores the default
//    register values; memory contents are not cleared (no clearing pass).
module drop_oldest_packet_ring_queue
  import dopq_pkg::*;
#(
  parameter int SLOT_DEPTH  = 16,
  parameter int STORE_BYTES = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  req_t             in_req,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_rsp
);

  localparam int SW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int CW = $clog2(SLOT_DEPTH + 1);
  localparam int AW = $clog2(STORE_BYTES);
  localparam int BW = $clog2(STORE_BYTES + 1);
  localparam int EW = ((BW > LEN_W) ? BW : LEN_W) + 1;
  localparam int PS_RST  = (SLOT_DEPTH < 16) ? SLOT_DEPTH : 16;
  localparam int CAP_RST = (STORE_BYTES < 4096) ? STORE_BYTES : 4096;

  typedef struct packed {
    logic [AW-1:0]     offset;
    logic [LEN_W-1:0]  length;
    logic [PRIO_W-1:0] prio;
  } desc_t;

  // storage
  desc_t        desc_mem [SLOT_DEPTH];
  logic [7:0]   store_mem [STORE_BYTES];
  desc_t        desc_q;
  logic [7:0]   store_q;

  // config and queue state
  logic [CW-1:0]    packet_slots;
  logic [BW-1:0]    byte_capacity;
  logic [SW-1:0]    head_index, head_index_next;
  logic [CW-1:0]    packet_count, packet_count_next;
  logic [BW-1:0]    bytes_in_use, bytes_in_use_next;
  logic [AW-1:0]    write_pointer, write_pointer_next;
  logic [LEN_W-1:0] write_remaining, write_remaining_next;
  logic [AW-1:0]    read_pointer, read_pointer_next;
  logic [LEN_W-1:0] read_remaining, read_remaining_next;

  // sequencer
  state_t        state, state_next;
  req_t          req;
  logic [AW-1:0] start, start_next;
  logic [CW-1:0] ndrop, ndrop_next;
  logic          rlast, rlast_next;

  logic  accept, done;
  rsp_t  rsp_next;
  logic          desc_we;
  logic [SW-1:0] desc_waddr, desc_raddr;
  desc_t         desc_wdata;
  logic          store_we;

  // shared arithmetic
  logic [CW:0]   tail_sum, last_sum;
  logic [SW-1:0] tail_idx, last_idx, head_inc;
  logic [CW-1:0] drop_count;
  logic [BW-1:0] drop_bytes;
  logic [EW-1:0] wrap_sum;
  logic [AW-1:0] wrap_start;
  logic [AW-1:0] wp_inc, rp_inc;
  req_t          cur;
  logic          too_long, evict_first, evict_more;

  assign accept = in_valid && !in_stall;
  assign in_stall = !((state == ST_IDLE) && (!out_valid || !out_stall));
  assign cur = (state == ST_IDLE) ? in_req : req;

  assign tail_sum = (CW+1)'(head_index) + (CW+1)'(packet_count);
  assign last_sum = tail_sum - (CW+1)'(1);
  assign tail_idx = (tail_sum >= (CW+1)'(packet_slots))
                    ? SW'(tail_sum - (CW+1)'(packet_slots)) : SW'(tail_sum);
  assign last_idx = (last_sum >= (CW+1)'(packet_slots))
                    ? SW'(last_sum - (CW+1)'(packet_slots)) : SW'(last_sum);
  assign head_inc = ((CW+1)'(head_index) + (CW+1)'(1) == (CW+1)'(packet_slots))
                    ? '0 : SW'(head_index + SW'(1));

  // drop-head unit, fed from the registered descriptor read
  assign drop_count = packet_count - CW'(1);
  assign drop_bytes = (EW'(bytes_in_use) >= EW'(desc_q.length))
                      ? BW'(EW'(bytes_in_use) - EW'(desc_q.length)) : '0;

  assign wrap_sum   = EW'(desc_q.offset) + EW'(desc_q.length);
  assign wrap_start = (wrap_sum >= EW'(byte_capacity))
                      ? AW'(wrap_sum - EW'(byte_capacity)) : AW'(wrap_sum);

  assign wp_inc = (EW'(write_pointer) + EW'(1) == EW'(byte_capacity))
                  ? '0 : AW'(write_pointer + AW'(1));
  assign rp_inc = (EW'(read_pointer) + EW'(1) == EW'(byte_capacity))
                  ? '0 : AW'(read_pointer + AW'(1));

  assign too_long = EW'(cur.pkt_length) >= EW'(byte_capacity);
  assign evict_first = (packet_count >= packet_slots) ||
                       (EW'(bytes_in_use) + EW'(req.pkt_length) > EW'(byte_capacity));
  assign evict_more = (drop_count != '0) &&
                      (EW'(drop_bytes) + EW'(req.pkt_length) > EW'(byte_capacity));

  // descriptor read address: look ahead one step of the sequencer
  always_comb begin
    priority case (1'b1)
      (state == ST_IDLE) && (in_req.cmd == CMD_ENQ): desc_raddr = last_idx;
      state == ST_EVICT:                             desc_raddr = head_inc;
      default:                                       desc_raddr = head_index;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.cmd)
            CMD_ENQ:  if (!too_long && packet_count != '0) state_next = ST_ENQ_LAST;
            CMD_DEQ:  if (packet_count != '0) state_next = ST_DEQ;
            CMD_DISC: if (packet_count != '0) state_next = ST_DISC;
            CMD_READ: if (read_remaining != '0) state_next = ST_RBYTE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ENQ_LAST: state_next = evict_first ? ST_EVICT : ST_ENQ_WR;
      ST_EVICT:    state_next = evict_more ? ST_EVICT : ST_ENQ_WR;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    head_index_next      = head_index;
    packet_count_next    = packet_count;
    bytes_in_use_next    = bytes_in_use;
    write_pointer_next   = write_pointer;
    write_remaining_next = write_remaining;
    read_pointer_next    = read_pointer;
    read_remaining_next  = read_remaining;
    start_next  = start;
    ndrop_next  = ndrop;
    rlast_next  = rlast;
    desc_we     = 1'b0;
    desc_waddr  = tail_idx;
    desc_wdata  = '{offset: start, length: req.pkt_length, prio: req.pkt_priority};
    store_we    = 1'b0;
    done        = 1'b0;
    rsp_next    = '0;
    rsp_next.status = STAT_EMPTY;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ndrop_next = '0;
          case (in_req.cmd)
            CMD_ENQ: begin
              if (too_long) begin
                done = 1'b1;
                rsp_next.status     = STAT_TOO_LONG;
                rsp_next.out_length = in_req.pkt_length;
              end else if (packet_count == '0) begin
                head_index_next      = '0;
                desc_we              = 1'b1;
                desc_waddr           = '0;
                desc_wdata           = '{offset: '0, length: in_req.pkt_length,
                                         prio: in_req.pkt_priority};
                packet_count_next    = CW'(1);
                bytes_in_use_next    = BW'(in_req.pkt_length);
                write_pointer_next   = '0;
                write_remaining_next = in_req.pkt_length;
                done = 1'b1;
                rsp_next.status     = STAT_OK;
                rsp_next.out_length = in_req.pkt_length;
              end
            end
            CMD_DATA: begin
              done = 1'b1;
              if (write_remaining != '0) begin
                store_we             = 1'b1;
                write_pointer_next   = wp_inc;
                write_remaining_next = write_remaining - LEN_W'(1);
                rsp_next.status      = STAT_OK;
              end
            end
            CMD_DEQ, CMD_DISC: done = (packet_count == '0);
            CMD_READ: begin
              if (read_remaining != '0) begin
                read_pointer_next   = rp_inc;
                read_remaining_next = read_remaining - LEN_W'(1);
                rlast_next          = (read_remaining == LEN_W'(1));
              end else begin
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      ST_RBYTE: begin
        done = 1'b1;
        rsp_next.status    = STAT_OK;
        rsp_next.out_byte  = store_q;
        rsp_next.last_byte = rlast;
      end
      ST_DEQ: begin
        done = 1'b1;
        rsp_next.out_length = desc_q.length;
        if (req.read_capacity < CAP_W'(desc_q.length)) begin
          rsp_next.status = STAT_SMALL;
        end else begin
          rsp_next.status       = STAT_OK;
          rsp_next.out_priority = desc_q.prio;
          read_pointer_next     = desc_q.offset;
          read_remaining_next   = desc_q.length;
          head_index_next       = head_inc;
          packet_count_next     = drop_count;
          bytes_in_use_next     = drop_bytes;
        end
      end
      ST_DISC: begin
        done = 1'b1;
        rsp_next.status   = STAT_OK;
        rsp_next.dropped  = CNT_W'(1);
        head_index_next   = head_inc;
        packet_count_next = drop_count;
        bytes_in_use_next = drop_bytes;
      end
      ST_ENQ_LAST: start_next = wrap_start;
      ST_EVICT: begin
        head_index_next   = head_inc;
        packet_count_next = drop_count;
        bytes_in_use_next = drop_bytes;
        ndrop_next        = ndrop + CW'(1);
      end
      ST_ENQ_WR: begin
        desc_we              = 1'b1;
        packet_count_next    = packet_count + CW'(1);
        bytes_in_use_next    = BW'(EW'(bytes_in_use) + EW'(req.pkt_length));
        write_pointer_next   = start;
        write_remaining_next = req.pkt_length;
        done = 1'b1;
        rsp_next.status     = STAT_OK;
        rsp_next.out_length = req.pkt_length;
        rsp_next.dropped    = CNT_W'(ndrop);
      end
      default: done = 1'b0;
    endcase
    rsp_next.queued_packets = CNT_W'(packet_count_next);
  end

  // memories
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_waddr] <= desc_wdata;
    end
    desc_q <= desc_mem[desc_raddr];
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[write_pointer] <= in_req.data_byte;
    end
    store_q <= store_mem[read_pointer];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_req;
    end
    start <= start_next;
    ndrop <= ndrop_next;
    rlast <= rlast_next;
    if (done) begin
      out_rsp <= rsp_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      packet_slots    <= CW'(PS_RST);
      byte_capacity   <= BW'(CAP_RST);
      head_index      <= '0;
      packet_count    <= '0;
      bytes_in_use    <= '0;
      write_pointer   <= '0;
      write_remaining <= '0;
      read_pointer    <= '0;
      read_remaining  <= '0;
    end else begin
      state <= state_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        // clamp, then empty the queue; store contents stay
        if (cfg_index == CFG_SLOTS) begin
          if (cfg_data[4:0] == '0) begin
            packet_slots <= CW'(1);
          end else if (32'(cfg_data[4:0]) > 32'(SLOT_DEPTH)) begin
            packet_slots <= CW'(SLOT_DEPTH);
          end else begin
            packet_slots <= CW'(cfg_data[4:0]);
          end
        end else begin
          if (cfg_data == '0) begin
            byte_capacity <= BW'(1);
          end else if (32'(cfg_data) > 32'(STORE_BYTES)) begin
            byte_capacity <= BW'(STORE_BYTES);
          end else begin
            byte_capacity <= BW'(cfg_data);
          end
        end
        head_index      <= '0;
        packet_count    <= '0;
        bytes_in_use    <= '0;
        write_pointer   <= '0;
        write_remaining <= '0;
        read_pointer    <= '0;
        read_remaining  <= '0;
      end else begin
        head_index      <= head_index_next;
        packet_count    <= packet_count_next;
        bytes_in_use    <= bytes_in_use_next;
        write_pointer   <= write_pointer_next;
        write_remaining <= write_remaining_next;
        read_pointer    <= read_pointer_next;
        read_remaining  <= read_remaining_next;
      end
    end
  end

endmodule

/* rtl/dopq_checker.sv */
// Port-level checks for the drop-oldest packet ring queue, with bind.
// Depends on dopq_pkg and the top level's port list.
module dopq_checker
  import dopq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input rsp_t out_rsp
);

  // held response must not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("response changed while stalled");

  // a held response blocks new requests
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while response held");

  // a taken request either answers at once or keeps the input stalled
  a_progress: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall || out_valid)
    else $error("request taken without response or stall");

  // a rejected enqueue drops nothing
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.status == STAT_TOO_LONG |-> out_rsp.dropped == '0)
    else $error("rejected enqueue dropped packets");

  // last-byte flag only on a successful read
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.last_byte |-> out_rsp.status == STAT_OK)
    else $error("last byte flagged on failed request");

endmodule

bind drop_oldest_packet_ring_queue dopq_checker u_dopq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
);

/* sim/drop_oldest_packet_ring_queue_tb.sv */
// Self-checking testbench for the drop-oldest packet ring queue.
// Depends on rtl/dopq_pkg.sv and rtl/drop_oldest_packet_ring_queue.sv.
// Keeps its own predictor of the queue and checks every response in order.
module drop_oldest_packet_ring_queue_tb import dopq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS_MAX = 16;
  localparam int STORE_MAX = 4096;
  localparam int WDOG_LIMIT = 5000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CAP_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  req_t             in_req;
  logic             out_valid;
  logic             out_stall;
  rsp_t             out_rsp;

  drop_oldest_packet_ring_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the queue.
  // ---------------------------------------------------------------------------
  int unsigned      slots_cfg;
  int unsigned      bytes_cfg;
  logic [11:0]      q_offset   [SLOTS_MAX];
  logic [11:0]      q_length   [SLOTS_MAX];
  logic [15:0]      q_priority [SLOTS_MAX];
  logic [7:0]       store      [STORE_MAX];
  bit               written    [STORE_MAX];  // store byte has been filled
  int unsigned      head, count, used;
  int unsigned      wr_ptr, wr_rem, rd_ptr, rd_rem;

  rsp_t             rsp_expected[$];
  int               n_errors;
  int               n_sent;         // requests accepted so far
  bit               no_idle;        // final stretch runs without bubbles
  bit               long_hold_req;  // asks the receiver for a long stall
  int               idle_cnt;

  function automatic void clear_queue();
    head = 0; count = 0; used = 0;
    wr_ptr = 0; wr_rem = 0; rd_ptr = 0; rd_rem = 0;
  endfunction

  function automatic void pop_head();
    int unsigned len;
    len = q_length[head % SLOTS_MAX];
    used = (used >= len) ? used - len : 0;
    head = (head + 1) % slots_cfg;
    count--;
  endfunction

  // Works out the response to one accepted request and advances the state.
  function automatic rsp_t predict_rsp(req_t r);
    rsp_t        s;
    int unsigned start, last, idx, len;
    s = '0;
    s.status = STAT_EMPTY;
    case (r.cmd)
      CMD_ENQ: begin
        if (r.pkt_length >= bytes_cfg) begin
          s.status = STAT_TOO_LONG;
          s.out_length = r.pkt_length;
        end else begin
          start = 0;
          if (count > 0) begin
            last = ((head + count - 1) % slots_cfg) % SLOTS_MAX;
            start = (q_offset[last] + q_length[last]) % bytes_cfg;
            if (count >= slots_cfg) begin
              pop_head();
              s.dropped++;
            end
            // evict oldest until the new packet fits
            while (count > 0 && used + r.pkt_length > bytes_cfg) begin
              pop_head();
              s.dropped++;
            end
          end else begin
            head = 0;
          end
          idx = ((head + count) % slots_cfg) % SLOTS_MAX;
          q_offset[idx] = 12'(start);
          q_length[idx] = r.pkt_length;
          q_priority[idx] = r.pkt_priority;
          count++;
          used += r.pkt_length;
          wr_ptr = start;
          wr_rem = r.pkt_length;
          s.status = STAT_OK;
          s.out_length = r.pkt_length;
        end
      end
      CMD_DATA: begin
        if (wr_rem > 0) begin
          store[wr_ptr % STORE_MAX] = r.data_byte;
          written[wr_ptr % STORE_MAX] = 1'b1;
          wr_ptr = (wr_ptr + 1) % bytes_cfg;
          wr_rem--;
          s.status = STAT_OK;
        end
      end
      CMD_DEQ: begin
        if (count > 0) begin
          len = q_length[head % SLOTS_MAX];
          s.out_length = 12'(len);
          if (r.read_capacity < len) begin
            s.status = STAT_SMALL;  // packet stays at the head
          end else begin
            s.out_priority = q_priority[head % SLOTS_MAX];
            rd_ptr = q_offset[head % SLOTS_MAX];
            rd_rem = len;
            pop_head();
            s.status = STAT_OK;
          end
        end
      end
      CMD_READ: begin
        if (rd_rem > 0) begin
          s.out_byte = store[rd_ptr % STORE_MAX];
          s.last_byte = (rd_rem == 1);
          rd_ptr = (rd_ptr + 1) % bytes_cfg;
          rd_rem--;
          s.status = STAT_OK;
        end
      end
      CMD_DISC: begin
        if (count > 0) begin
          pop_head();
          s.dropped = 5'd1;
          s.status = STAT_OK;
        end
      end
      default: ;  // unknown command: empty status, no change
    endcase
    s.queued_packets = 5'(count);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one request at a time, optional bubble in front of it.
  // Prediction happens at the accepting edge so state stays in order.
  // ---------------------------------------------------------------------------
  task automatic send_req(req_t r);
    if (!no_idle && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 19)) @(negedge clk);
    in_valid = 1'b1;
    in_req = r;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    rsp_expected.push_back(predict_rsp(r));
    n_sent++;
    @(negedge clk);
    in_valid = 1'b0;
    in_req = '0;
  endtask

  function automatic req_t make_req(logic [2:0] c);
    req_t r;
    r.cmd = c;
    r.data_byte = 8'($urandom);
    r.pkt_length = 12'($urandom);
    r.pkt_priority = 16'($urandom);
    r.read_capacity = 13'($urandom);
    return r;
  endfunction

  task automatic send_enq(int unsigned len, logic [15:0] prio);
    req_t r;
    r = make_req(CMD_ENQ);
    r.pkt_length = 12'(len);
    r.pkt_priority = prio;
    send_req(r);
  endtask

  task automatic send_deq(int unsigned rcap);
    req_t r;
    r = make_req(CMD_DEQ);
    r.read_capacity = 13'(rcap);
    send_req(r);
  endtask

  // Streams the pending packet, but never past a byte that was not filled.
  task automatic read_pending(int unsigned max_n);
    int unsigned i;
    i = 0;
    while (i < max_n && rd_rem > 0 && written[rd_ptr % STORE_MAX]) begin
      send_req(make_req(CMD_READ));
      i++;
    end
  endtask

  task automatic write_pending(int unsigned max_n);
    int unsigned i;
    for (i = 0; i < max_n && wr_rem > 0; i++)
      send_req(make_req(CMD_DATA));
  endtask

  // Register write only once the block has gone quiet.
  task automatic write_cfg(logic idx, logic [CAP_W-1:0] val);
    int unsigned v;
    wait (rsp_expected.size() == 0);
    repeat (40) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SLOTS) begin
      v = val & 5'h1f;
      slots_cfg = (v < 1) ? 1 : (v > SLOTS_MAX) ? SLOTS_MAX : v;
    end else begin
      v = val;
      bytes_cfg = (v < 1) ? 1 : (v > STORE_MAX) ? STORE_MAX : v;
    end
    clear_queue();
  endtask

  // Mostly whole packets in and out with random content, plus noise.
  task automatic run_random(int n_items);
    int          target;
    int unsigned len, hi, k;
    target = n_sent + n_items;
    while (n_sent < target) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        hi = (bytes_cfg > 13) ? 12 : bytes_cfg - 1;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, bytes_cfg)
                                           : $urandom_range(0, hi);
        send_enq(len, 16'($urandom));
        // long packets only get a short head of data
        write_pending((len > hi || $urandom_range(0, 5) == 0)
                      ? $urandom_range(0, (len > hi) ? hi : len) : len);
      end else if (k < 75) begin
        len = (count > 0) ? q_length[head % SLOTS_MAX] : 0;
        send_deq(($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191)
                                             : $urandom_range(len, 8191));
        read_pending(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 16);
      end else if (k < 85) begin
        send_req(make_req(CMD_DISC));
      end else begin
        // noise: any command code, any field values, no unfilled reads
        send_req(make_req((rd_rem > 0 && !written[rd_ptr % STORE_MAX])
                          ? CMD_DEQ : 3'($urandom_range(0, 7))));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // empty and nothing-pending cases, unknown codes
    send_deq(13'h1fff);
    send_req(make_req(CMD_DISC));
    send_req(make_req(CMD_READ));
    send_req(make_req(CMD_DATA));
    send_req(make_req(3'd5));
    send_req(make_req(3'd7));
    // longest packet the full store takes, early dequeue after two bytes
    send_enq(12'hfff, 16'hffff);
    send_req('{cmd: CMD_DATA, data_byte: 8'h00, default: '0});
    send_req('{cmd: CMD_DATA, data_byte: 8'hff, default: '0});
    send_deq(13'd0);          // buffer too small, packet kept
    send_deq(13'h1fff);
    read_pending(4);
    // zero-length packet, then a new enqueue abandoning a pending write
    send_enq(0, 16'h0000);
    send_deq(0);
    send_enq(3, 16'h1234);
    send_enq(2, 16'h8001);
    write_pending(2);
    send_deq(2);
    read_pending(2);
  endtask

  task automatic test_limits();
    write_cfg(CFG_BYTES, 13'd16);
    send_enq(16, 16'h5555);   // too long
    send_enq(15, 16'haaaa);
    write_pending(15);
    send_enq(4, 16'h0f0f);    // byte eviction
    write_pending(4);
    write_cfg(CFG_SLOTS, 13'd2);
    send_enq(1, 16'd1); send_enq(1, 16'd2); send_enq(1, 16'd3);  // slot eviction
    write_cfg(CFG_SLOTS, 13'd0);   // clamps to one slot
    write_cfg(CFG_BYTES, 13'd0);   // clamps to one byte
    run_random(25);
  endtask

  task automatic test_settings();
    write_cfg(CFG_SLOTS, 13'd31);  // clamps to the full ring
    write_cfg(CFG_BYTES, 13'h1fff);
    run_random(100);
    write_cfg(CFG_SLOTS, 13'd4);
    write_cfg(CFG_BYTES, 13'd40);
    run_random(100);
    write_cfg(CFG_SLOTS, 13'($urandom_range(1, 16)));
    write_cfg(CFG_BYTES, 13'($urandom_range(1, 64)));
    run_random(80);
  endtask

  // Receiver holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    write_cfg(CFG_SLOTS, 13'd16);
    write_cfg(CFG_BYTES, 13'd200);
    long_hold_req = 1'b1;
    run_random(100);
  endtask

  task automatic test_no_gaps();
    no_idle = 1'b1;
    run_random(100);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stall bursts, plus the long hold on request.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int burst_left;
    bit burst_on;
    hold_left = 0;
    burst_left = 0;
    burst_on = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall = burst_on;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(1, 19) - 1;
        burst_on = 1'b1;
        out_stall = 1'b1;
      end else begin
        // stretches with no stall at all
        burst_left = $urandom_range(0, 30);
        burst_on = 1'b0;
        out_stall = 1'b0;
      end
    end
  end

  // Compare each accepted response with the oldest prediction.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (rsp_expected.size() == 0) begin
        $error("response with none expected: %h", out_rsp);
        n_errors++;
      end else begin
        e = rsp_expected.pop_front();
        if (out_rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_rsp.status);
          n_errors++;
        end
        if (out_rsp.out_length !== e.out_length) begin
          $error("out_length exp %0d got %0d", e.out_length, out_rsp.out_length);
          n_errors++;
        end
        if (out_rsp.out_priority !== e.out_priority) begin
          $error("out_priority exp %h got %h", e.out_priority, out_rsp.out_priority);
          n_errors++;
        end
        if (out_rsp.out_byte !== e.out_byte) begin
          $error("out_byte exp %h got %h", e.out_byte, out_rsp.out_byte);
          n_errors++;
        end
        if (out_rsp.last_byte !== e.last_byte) begin
          $error("last_byte exp %b got %b", e.last_byte, out_rsp.last_byte);
          n_errors++;
        end
        if (out_rsp.dropped !== e.dropped) begin
          $error("dropped exp %0d got %0d", e.dropped, out_rsp.dropped);
          n_errors++;
        end
        if (out_rsp.queued_packets !== e.queued_packets) begin
          $error("queued_packets exp %0d got %0d", e.queued_packets,
                 out_rsp.queued_packets);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: too long with nothing moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_LIMIT) begin
      $display("drop_oldest_packet_ring_queue_tb: errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req = '0;
    n_sent = 0;
    no_idle = 1'b0;
    long_hold_req = 1'b0;
    slots_cfg = SLOTS_MAX;
    bytes_cfg = STORE_MAX;
    clear_queue();
    foreach (written[i]) written[i] = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_limits();
    test_settings();
    test_backpressure();
    test_no_gaps();

    wait (rsp_expected.size() == 0);
    repeat (40) @(negedge clk);
    if (n_errors == 0 && rsp_expected.size() == 0) begin
      $display("drop_oldest_packet_ring_queue_tb: clean");
    end else begin
      $display("drop_oldest_packet_ring_queue_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dopq_pkg.sv
rtl/drop_oldest_packet_ring_queue.sv
rtl/dopq_checker.sv
sim/drop_oldest_packet_ring_queue_tb.sv
